[design/mwgl_pkg.sv]
package mwgl_pkg;

    // Register and digest geometry
    localparam int MAX_WIDTH       = 4096;
    localparam int DIGEST_WORDS    = 8;
    localparam int WORD_BITS       = 64;
    localparam int DIGEST_BITS     = DIGEST_WORDS * WORD_BITS;
    localparam int N_PRESETS       = 16;
    localparam int N_TAPS          = 4;
    localparam int FALLBACK_PRESET = 15;
    localparam int BYTE_BITS       = 8;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    // Digest word that completes seeding
    localparam logic [2:0] LAST_WORD = 3'd7;

    typedef logic [MAX_WIDTH-1:0]   t_state;
    typedef logic [DIGEST_BITS-1:0] t_digest;
    typedef logic [3:0]             t_preset;
    typedef logic [12:0]            t_tap;

    // Per-beat control into the generator core
    typedef struct packed {
        logic load;
        logic gen;
    } t_ctl;

    // Preset table: four taps per row, the first of which is the register width
    localparam t_tap PRESETS [N_PRESETS][N_TAPS] = '{
        '{13'd4096, 13'd4095, 13'd4081, 13'd4069},
        '{13'd2048, 13'd2035, 13'd2034, 13'd2029},
        '{13'd777,  13'd776,  13'd767,  13'd761 },
        '{13'd667,  13'd664,  13'd660,  13'd649 },
        '{13'd666,  13'd664,  13'd659,  13'd656 },
        '{13'd665,  13'd661,  13'd659,  13'd654 },
        '{13'd589,  13'd586,  13'd585,  13'd579 },
        '{13'd512,  13'd510,  13'd507,  13'd504 },
        '{13'd444,  13'd435,  13'd432,  13'd431 },
        '{13'd333,  13'd331,  13'd329,  13'd325 },
        '{13'd303,  13'd297,  13'd291,  13'd290 },
        '{13'd256,  13'd254,  13'd251,  13'd246 },
        '{13'd222,  13'd220,  13'd217,  13'd214 },
        '{13'd128,  13'd127,  13'd126,  13'd121 },
        '{13'd111,  13'd109,  13'd107,  13'd104 },
        '{13'd64,   13'd63,   13'd61,   13'd60  }
    };

    // Presets wider than the register fall back to the narrowest one
    function automatic t_preset active_preset(input t_preset sel);
        t_preset p;
        p = sel;
        if (int'(PRESETS[sel][0]) > MAX_WIDTH) begin
            p = t_preset'(FALLBACK_PRESET);
        end
        return p;
    endfunction

    // Ones below the preset width
    function automatic t_state width_mask(input t_preset p);
        t_state m;
        int     w;
        w = int'(PRESETS[p][0]);
        for (int i = 0; i < MAX_WIDTH; i++) begin
            m[i] = (i < w);
        end
        return m;
    endfunction

    // Feedback positions (width - tap) for one shift
    function automatic t_state tap_mask(input t_preset p);
        t_state m;
        int     w;
        w = int'(PRESETS[p][0]);
        m = '0;
        for (int t = 0; t < N_TAPS; t++) begin
            m[w - int'(PRESETS[p][t])] = ~m[w - int'(PRESETS[p][t])];
        end
        return m;
    endfunction

    // Top eight bits of the active width, top bit in the MSB
    function automatic logic [BYTE_BITS-1:0] top_byte(input t_state s, input t_preset p);
        logic [BYTE_BITS-1:0] b;
        int                   w;
        w = int'(PRESETS[p][0]);
        for (int k = 0; k < BYTE_BITS; k++) begin
            b[BYTE_BITS-1-k] = s[w-1-k];
        end
        return b;
    endfunction

endpackage

[design/mwgl_req_if.sv]
interface mwgl_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  word_index;
    logic [63:0] digest_word;

    modport source (output valid, output req_type, output word_index,
                    output digest_word, input ready);
    modport sink   (input valid, input req_type, input word_index,
                    input digest_word, output ready);
endinterface

[design/mwgl_rsp_if.sv]
interface mwgl_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;

    modport source (output valid, output random_byte, input ready);
    modport sink   (input valid, input random_byte, output ready);
endinterface

[design/mwgl_core.sv]
module mwgl_core
    import mwgl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [2:0]           i_word_index,
    input  logic [63:0]          i_digest_word,
    output logic [BYTE_BITS-1:0] o_byte
);

    t_state                      r_state, n_state;
    logic [WORD_BITS-1:0]        r_seed [DIGEST_WORDS];
    logic [WORD_BITS-1:0]        n_seed [DIGEST_WORDS];
    t_preset                     r_preset, n_preset;

    t_state                      wmask, tmask, shifted, acc, fill;
    t_digest                     dvec;
    logic [BYTE_BITS-1:0]        out_bits;

    // Output bits of the next eight shifts: taps sit far below the top,
    // so the eight bits leaving are simply the current top eight
    always_comb begin
        wmask    = width_mask(r_preset);
        tmask    = tap_mask(r_preset);
        out_bits = top_byte(r_state, r_preset);
    end

    assign o_byte = out_bits;

    // Eight Galois shifts folded: shift by eight, then feedback per bit
    always_comb begin
        shifted = (r_state << BYTE_BITS) & wmask;
        acc     = shifted;
        for (int k = 0; k < BYTE_BITS; k++) begin
            if (out_bits[BYTE_BITS-1-k]) begin
                acc = acc ^ (tmask << (BYTE_BITS-1-k));
            end
        end
    end

    // Seed store and completion fill
    always_comb begin
        n_seed   = r_seed;
        n_preset = r_preset;
        n_state  = r_state;
        if (i_ctl.load) begin
            n_seed[i_word_index] = i_digest_word;
        end
        // digest bit d sits at word d/64, MSB first
        for (int i = 0; i < DIGEST_BITS; i++) begin
            dvec[i] = n_seed[i / WORD_BITS][WORD_BITS-1 - (i % WORD_BITS)];
        end
        if (i_ctl.load && i_word_index == LAST_WORD) begin
            n_preset = active_preset(i_digest_word[3:0]);
        end
        for (int i = 0; i < MAX_WIDTH; i++) begin
            fill[i] = dvec[i % DIGEST_BITS];
        end
        fill = fill & width_mask(n_preset);
        if (i_ctl.load) begin
            if (i_word_index == LAST_WORD) begin
                n_state = fill;
            end
        end else if (i_ctl.gen) begin
            n_state = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_preset <= active_preset('0);
            for (int j = 0; j < DIGEST_WORDS; j++) begin
                r_seed[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_preset <= n_preset;
            r_seed   <= n_seed;
        end
    end

endmodule

[design/multi_width_galois_lfsr_bytes.sv]
// Galois LFSR byte generator, preset widths from 64 to 4096 bits.
//
// Request channel i_req: a beat with req_type = load stores digest_word as
// seed word word_index; loading word 7 also picks the preset from its low
// four bits and refills the shift register from the 512-bit digest. A beat
// with req_type = byte runs eight shifts and returns one random_byte on o_rsp.
// Loads return nothing.
//
// A byte request is registered by the edge that accepts it and shows on
// o_rsp after that edge. One request per cycle is taken while i_req.ready
// is high; the eight shifts are one pass of logic on the state register,
// so back-to-back bytes see each other's state updates with no bubbles.
//
// Reset (synchronous, active low) clears the register, all seed words and
// selects the 4096-bit preset; a byte before seeding reads zero.
// A one-beat output register sits before o_rsp. While a result waits and
// the receiver stalls, i_req.ready drops; it stays high when the register
// is empty or being drained in the same cycle.
module multi_width_galois_lfsr_bytes
    import mwgl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mwgl_req_if.sink        i_req,
    mwgl_rsp_if.source      o_rsp
);

    logic                 r_out_valid;
    logic [BYTE_BITS-1:0] r_out_byte;
    logic [BYTE_BITS-1:0] core_byte;
    logic                 accept;
    t_ctl                 ctl;

    // Request side handshake
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign ctl.load    = accept && (i_req.req_type == REQ_LOAD);
    assign ctl.gen     = accept && (i_req.req_type == REQ_BYTE);

    mwgl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_word_index  (i_req.word_index),
        .i_digest_word (i_req.digest_word),
        .o_byte        (core_byte)
    );

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.gen) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.gen) begin
            r_out_byte <= core_byte;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.random_byte = r_out_byte;

endmodule
